// ===== hdl/pidl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_pkg: shared definitions for the positional insert/delete list
// Holds the list capacity, derived widths, status codes, the controller
// state type and the command bundle passed from controller to datapath.
// ----------------------------------------------------------------------------
package pidl_pkg;

    // Number of words the list can hold.
    localparam int CAPACITY = 16;

    // Width of the position and length fields on the ports.
    localparam int POS_W = 5;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Width of the entry count, wide enough to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Width of an index into the store.
    localparam int IDX_W = $clog2(CAPACITY);

    // Width used to compare positions against the count without overflow.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Operation codes carried by the cmd field.
    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // Controller states: result register empty or holding a result.
    typedef enum logic
    {
        CTRL_EMPTY = 1'b0,
        CTRL_HOLD  = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic execute;      // perform the accepted transaction this cycle
        logic load_result;  // capture the transaction's result
    } dp_cmd_t;

endpackage

// ===== hdl/pidl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_ctrl: handshake controller for the positional insert/delete list
// Tracks whether the result register holds an undelivered result and
// decides when a request transaction is accepted.
// ----------------------------------------------------------------------------
module pidl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pidl_pkg::dp_cmd_t dp_cmd
);

    pidl_pkg::ctrl_state_t state_reg;
    pidl_pkg::ctrl_state_t state_next;
    logic                  accept;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidl_pkg::CTRL_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs. A new request is taken whenever the result
    // register is empty or its result is being delivered in this cycle.
    always_comb
    begin
        req_stall  = 1'b0;
        rsp_valid  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            pidl_pkg::CTRL_EMPTY:
            begin
                req_stall = 1'b0;
                rsp_valid = 1'b0;
            end
            pidl_pkg::CTRL_HOLD:
            begin
                req_stall = rsp_stall;
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b0;
                rsp_valid = 1'b0;
            end
        endcase

        accept = req_valid && !req_stall;

        if (accept)
        begin
            state_next = pidl_pkg::CTRL_HOLD;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            state_next = pidl_pkg::CTRL_EMPTY;
        end

        dp_cmd.execute     = accept;
        dp_cmd.load_result = accept;
    end

endmodule

// ===== hdl/pidl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_dp: datapath for the positional insert/delete list
// Holds the entry store as a row of registers, each of which keeps its word,
// takes a neighbour's or takes the new word, plus the count and the result register.
// ----------------------------------------------------------------------------
module pidl_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pidl_pkg::dp_cmd_t                 dp_cmd,
    input  logic                              cmd,
    input  logic [pidl_pkg::POS_W-1:0]        position,
    input  logic signed [pidl_pkg::WORD_W-1:0] value,
    output logic [1:0]                        status,
    output logic signed [pidl_pkg::WORD_W-1:0] removed_value,
    output logic [pidl_pkg::POS_W-1:0]        list_length
);

    logic [pidl_pkg::WORD_W-1:0] entries_reg  [pidl_pkg::CAPACITY];
    logic [pidl_pkg::WORD_W-1:0] entries_next [pidl_pkg::CAPACITY];
    logic [pidl_pkg::CNT_W-1:0]  count_reg;
    logic [pidl_pkg::CNT_W-1:0]  count_next;

    pidl_pkg::status_t            status_reg;
    pidl_pkg::status_t            status_next;
    logic [pidl_pkg::WORD_W-1:0]  removed_reg;
    logic [pidl_pkg::WORD_W-1:0]  removed_next;
    logic [pidl_pkg::POS_W-1:0]   length_reg;

    logic [pidl_pkg::CMP_W-1:0]   pos_x;
    logic [pidl_pkg::CMP_W-1:0]   cnt_x;
    logic [pidl_pkg::CMP_W-1:0]   pos_m1;
    logic [pidl_pkg::IDX_W-1:0]   idx;
    logic                         ins_pos_ok;
    logic                         del_pos_ok;
    logic                         is_full;
    logic                         do_ins;
    logic                         do_del;

    // Position checks against the current count.
    always_comb
    begin
        pos_x      = pidl_pkg::CMP_W'(position);
        cnt_x      = pidl_pkg::CMP_W'(count_reg);
        pos_m1     = pos_x - pidl_pkg::CMP_W'(1);
        idx        = pos_m1[pidl_pkg::IDX_W-1:0];
        ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + pidl_pkg::CMP_W'(1));
        del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
        is_full    = (cnt_x >= pidl_pkg::CMP_W'(pidl_pkg::CAPACITY));
    end

    // Status, removed word and operation enables.
    always_comb
    begin
        do_ins       = 1'b0;
        do_del       = 1'b0;
        removed_next = '0;
        status_next  = pidl_pkg::STATUS_OK;
        if (cmd == pidl_pkg::OP_INSERT)
        begin
            priority if (!ins_pos_ok)
            begin
                status_next = pidl_pkg::STATUS_BAD_POS;
            end
            else if (is_full)
            begin
                status_next = pidl_pkg::STATUS_FULL;
            end
            else
            begin
                do_ins = 1'b1;
            end
        end
        else
        begin
            if (!del_pos_ok)
            begin
                status_next = pidl_pkg::STATUS_BAD_POS;
            end
            else
            begin
                do_del       = 1'b1;
                removed_next = entries_reg[idx];
            end
        end
    end

    // Each entry holds, takes its lower neighbour (insert) or its upper
    // neighbour (delete), or takes the new word at the insert point.
    always_comb
    begin
        for (int k = 0; k < pidl_pkg::CAPACITY; k++)
        begin
            entries_next[k] = entries_reg[k];
            if (do_ins)
            begin
                if (pidl_pkg::CMP_W'(k) == pos_m1)
                begin
                    entries_next[k] = value;
                end
                else if ((pidl_pkg::CMP_W'(k) > pos_m1) && (k > 0))
                begin
                    entries_next[k] = entries_reg[(k > 0) ? k - 1 : 0];
                end
            end
            else if (do_del)
            begin
                if ((pidl_pkg::CMP_W'(k) >= pos_m1) && (k < pidl_pkg::CAPACITY - 1))
                begin
                    entries_next[k] =
                        entries_reg[(k < pidl_pkg::CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    end

    // Count update.
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + pidl_pkg::CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - pidl_pkg::CNT_W'(1);
        end
    end

    // Control state: the count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    // Entry store, no reset: entries at or beyond the count are never read.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.execute)
        begin
            for (int k = 0; k < pidl_pkg::CAPACITY; k++)
            begin
                entries_reg[k] <= entries_next[k];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_result)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            length_reg  <= pidl_pkg::POS_W'(count_next);
        end
    end

    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign list_length   = length_reg;

endmodule

// ===== hdl/positional_insert_delete_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list: ordered list with insert/delete by position
// Keeps up to CAPACITY signed words in order; insert and delete work at a
// 1-based position and shift the later entries in parallel.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall) carries cmd, position and
// value. A transaction is taken at a rising edge with req_valid high and
// req_stall low. Each request yields exactly one response on the response
// channel (rsp_valid, rsp_stall) with status, removed_value and list_length.
// The response is valid in the cycle after the request is taken.
// Throughput is one request per cycle while the receiver does not stall, set by
// the row of entry registers, which all shift to their neighbour in parallel.
// The response register is a single stage; while it holds an undelivered
// result and the receiver stalls, req_stall is raised and the response
// stays unchanged. A new request is taken in the same cycle as the held
// response is delivered.
// Reset empties the list and the response register; entry contents are
// not cleared, since entries beyond the current length are never read.
// ----------------------------------------------------------------------------
module positional_insert_delete_list
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               cmd,
    input  logic [pidl_pkg::POS_W-1:0]         position,
    input  logic signed [pidl_pkg::WORD_W-1:0] value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [1:0]                         status,
    output logic signed [pidl_pkg::WORD_W-1:0] removed_value,
    output logic [pidl_pkg::POS_W-1:0]         list_length
);

    pidl_pkg::dp_cmd_t dp_cmd;

    // Handshake controller.
    pidl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_cmd    (dp_cmd)
    );

    // Entry store, count and result register.
    pidl_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .status        (status),
        .removed_value (removed_value),
        .list_length   (list_length)
    );

endmodule

// ===== verif/positional_insert_delete_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_test: self-checking bench for the list block
// Sends insert and delete transactions, first from a table of directed cases
// and then at random. A shadow copy of the list predicts every response, and
// each response is checked field by field. Sender gaps, receiver stalls and
// one long receiver hold-off are applied throughout.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_test;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_ITEMS     = 1000;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_START  = 500;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DIRECTED_ROWS    = 26;
    localparam int MAX_POSITION     = (1 << pidl_pkg::POS_W) - 1;

    localparam logic signed [pidl_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [pidl_pkg::WORD_W-1:0] WORD_MIN = 32'sh80000000;

    // Receiver behaviour over one stretch of cycles.
    typedef enum int
    {
        STALL_NONE,
        STALL_COIN,
        STALL_ALTERNATE,
        STALL_HEAVY,
        STALL_HOLD
    } stall_mode_t;

    // One response as the block should report it.
    typedef struct
    {
        pidl_pkg::status_t                  status;
        logic signed [pidl_pkg::WORD_W-1:0] removed;
        logic [pidl_pkg::POS_W-1:0]         length;
    } list_result_t;

    // One row of the directed table; a row may be repeated with the word
    // incremented on each repetition.
    typedef struct
    {
        pidl_pkg::op_t                      op;
        int                                 pos;
        logic signed [pidl_pkg::WORD_W-1:0] word;
        int                                 reps;
        bit                                 typed;
        list_result_t                       result;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               req_valid;
    logic                               req_stall;
    logic                               cmd;
    logic [pidl_pkg::POS_W-1:0]         position;
    logic signed [pidl_pkg::WORD_W-1:0] value;
    logic                               rsp_valid;
    logic                               rsp_stall;
    logic [1:0]                         status;
    logic signed [pidl_pkg::WORD_W-1:0] removed_value;
    logic [pidl_pkg::POS_W-1:0]         list_length;

    // Shadow copy of the list.
    logic signed [pidl_pkg::WORD_W-1:0] shadow_words [pidl_pkg::CAPACITY];
    int                                 shadow_count;

    list_result_t pending_results [$];
    list_result_t oldest;
    stim_row_t    directed_rows [DIRECTED_ROWS];

    int error_count;
    int quiet_cycles;
    int burst_left;
    int insert_ok;
    int delete_ok;
    int bad_pos_hits;
    int full_hits;
    int peak_length;

    positional_insert_delete_list dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .removed_value (removed_value),
        .list_length   (list_length)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Applies one transaction to the shadow list and returns its response.
    function automatic list_result_t apply_list_op
    (
        input pidl_pkg::op_t                      op,
        input logic [pidl_pkg::POS_W-1:0]         pos,
        input logic signed [pidl_pkg::WORD_W-1:0] word
    );
        list_result_t res;
        int           p;
        int           k;
        p           = int'(pos);
        res.status  = pidl_pkg::STATUS_OK;
        res.removed = '0;
        if (op == pidl_pkg::OP_INSERT)
        begin
            if (p < 1 || p > shadow_count + 1)
            begin
                res.status = pidl_pkg::STATUS_BAD_POS;
            end
            else if (shadow_count >= pidl_pkg::CAPACITY)
            begin
                res.status = pidl_pkg::STATUS_FULL;
            end
            else
            begin
                for (k = shadow_count; k >= p; k--)
                begin
                    shadow_words[k] = shadow_words[k - 1];
                end
                shadow_words[p - 1] = word;
                shadow_count++;
                insert_ok++;
            end
        end
        else
        begin
            if (p < 1 || p > shadow_count)
            begin
                res.status = pidl_pkg::STATUS_BAD_POS;
            end
            else
            begin
                res.removed = shadow_words[p - 1];
                for (k = p; k < shadow_count; k++)
                begin
                    shadow_words[k - 1] = shadow_words[k];
                end
                shadow_count--;
                delete_ok++;
            end
        end
        if (res.status == pidl_pkg::STATUS_BAD_POS)
        begin
            bad_pos_hits++;
        end
        if (res.status == pidl_pkg::STATUS_FULL)
        begin
            full_hits++;
        end
        if (shadow_count > peak_length)
        begin
            peak_length = shadow_count;
        end
        res.length = pidl_pkg::POS_W'(shadow_count);
        return res;
    endfunction

    // Offers one transaction, inserting a sender gap at the end of a burst,
    // and records the expected response once the block has taken it.
    task automatic send_item
    (
        input pidl_pkg::op_t                      op,
        input logic [pidl_pkg::POS_W-1:0]         pos,
        input logic signed [pidl_pkg::WORD_W-1:0] word,
        input bit                                 typed,
        input list_result_t                       typed_result
    );
        int           gap;
        list_result_t predicted;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= op;
        position  <= pos;
        value     <= word;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        predicted = apply_list_op(op, pos, word);
        pending_results.push_back(typed ? typed_result : predicted);
        burst_left--;
    endtask

    // Main stimulus: directed table, then random transactions, then drain.
    initial
    begin : stimulus
        int                                 r;
        int                                 n;
        int                                 pos;
        int                                 top_pos;
        bit                                 fill_phase;
        pidl_pkg::op_t                      op;
        logic signed [pidl_pkg::WORD_W-1:0] word;
        list_result_t                       no_result;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        cmd          = pidl_pkg::OP_INSERT;
        position     = '0;
        value        = '0;
        shadow_count = 0;
        error_count  = 0;
        burst_left   = 0;
        insert_ok    = 0;
        delete_ok    = 0;
        bad_pos_hits = 0;
        full_hits    = 0;
        peak_length  = 0;
        fill_phase   = 1'b1;
        no_result    = '{pidl_pkg::STATUS_OK, '0, '0};

        directed_rows = '{
            // Empty: every delete and any insert at 0 or past the end fail.
            '{pidl_pkg::OP_DELETE, 1, 0, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 0}},
            '{pidl_pkg::OP_DELETE, 0, 0, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 0}},
            '{pidl_pkg::OP_INSERT, 0, 5, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 0}},
            '{pidl_pkg::OP_INSERT, 2, 5, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 0}},
            '{pidl_pkg::OP_INSERT, 31, 5, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 0}},
            // Extreme words at head, then tail and middle; then all deleted.
            '{pidl_pkg::OP_INSERT, 1, WORD_MAX, 1, 1'b1, '{pidl_pkg::STATUS_OK, 0, 1}},
            '{pidl_pkg::OP_INSERT, 1, WORD_MIN, 1, 1'b1, '{pidl_pkg::STATUS_OK, 0, 2}},
            '{pidl_pkg::OP_INSERT, 3, -1, 1, 1'b1, '{pidl_pkg::STATUS_OK, 0, 3}},
            '{pidl_pkg::OP_INSERT, 2, 0, 1, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            '{pidl_pkg::OP_DELETE, 5, 0, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 4}},
            '{pidl_pkg::OP_DELETE, 1, 0, 1, 1'b1, '{pidl_pkg::STATUS_OK, WORD_MIN, 3}},
            '{pidl_pkg::OP_DELETE, 3, 0, 1, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            '{pidl_pkg::OP_DELETE, 2, 0, 1, 1'b1, '{pidl_pkg::STATUS_OK, WORD_MAX, 1}},
            '{pidl_pkg::OP_DELETE, 1, 0, 1, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            // Fill from the head, try past capacity, then work at the tail.
            '{pidl_pkg::OP_INSERT, 1, 32'sh00001000, 16, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            '{pidl_pkg::OP_INSERT, 17, 7, 1, 1'b1, '{pidl_pkg::STATUS_FULL, 0, 16}},
            '{pidl_pkg::OP_INSERT, 1, 7, 1, 1'b1, '{pidl_pkg::STATUS_FULL, 0, 16}},
            '{pidl_pkg::OP_INSERT, 18, 7, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 16}},
            '{pidl_pkg::OP_DELETE, 16, 0, 1, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            '{pidl_pkg::OP_DELETE, 16, 0, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 15}},
            '{pidl_pkg::OP_INSERT, 16, 32'sh5555aaaa, 1, 1'b1, '{pidl_pkg::STATUS_OK, 0, 16}},
            '{pidl_pkg::OP_DELETE, 16, 0, 1, 1'b1, '{pidl_pkg::STATUS_OK, 32'sh5555aaaa, 15}},
            // Drain from middle and head until empty, then insert once.
            '{pidl_pkg::OP_DELETE, 8, 0, 1, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            '{pidl_pkg::OP_DELETE, 1, 0, 14, 1'b0, '{pidl_pkg::STATUS_OK, 0, 0}},
            '{pidl_pkg::OP_DELETE, 1, 0, 1, 1'b1, '{pidl_pkg::STATUS_BAD_POS, 0, 0}},
            '{pidl_pkg::OP_INSERT, 1, 32'shaaaa5555, 1, 1'b1, '{pidl_pkg::STATUS_OK, 0, 1}}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            for (n = 0; n < directed_rows[r].reps; n++)
            begin
                send_item(directed_rows[r].op, pidl_pkg::POS_W'(directed_rows[r].pos),
                          directed_rows[r].word + n, directed_rows[r].typed,
                          directed_rows[r].result);
            end
        end

        // Random part: mostly legal positions, trending between filling the
        // list up and draining it, with some noise at any position.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (shadow_count == 0)
            begin
                fill_phase = 1'b1;
            end
            else if (shadow_count == pidl_pkg::CAPACITY && $urandom_range(0, 3) == 0)
            begin
                fill_phase = 1'b0;
            end
            case ($urandom_range(0, 5))
                0:       word = WORD_MAX;
                1:       word = WORD_MIN;
                2:       word = $signed($urandom_range(0, 20)) - 10;
                default: word = $urandom;
            endcase
            if ($urandom_range(0, 99) < 12)
            begin
                op  = pidl_pkg::op_t'($urandom_range(0, 1));
                pos = $urandom_range(0, MAX_POSITION);
            end
            else
            begin
                if (fill_phase)
                begin
                    op = ($urandom_range(0, 99) < 75) ? pidl_pkg::OP_INSERT
                                                       : pidl_pkg::OP_DELETE;
                end
                else
                begin
                    op = ($urandom_range(0, 99) < 25) ? pidl_pkg::OP_INSERT
                                                       : pidl_pkg::OP_DELETE;
                end
                if (op == pidl_pkg::OP_DELETE && shadow_count == 0)
                begin
                    op = pidl_pkg::OP_INSERT;
                end
                top_pos = (op == pidl_pkg::OP_INSERT) ? shadow_count + 1 : shadow_count;
                case ($urandom_range(0, 3))
                    0:       pos = 1;
                    1:       pos = top_pos;
                    default: pos = $urandom_range(1, top_pos);
                endcase
            end
            send_item(op, pidl_pkg::POS_W'(pos), word, 1'b0, no_result);
        end

        @(negedge clk);
        req_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d good inserts, %0d good deletes, %0d bad positions, %0d full",
                 insert_ok, delete_ok, bad_pos_hits, full_hits);
        $display("Longest list reached %0d of %0d entries; %0d errors",
                 peak_length, pidl_pkg::CAPACITY, error_count);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Receiver stall pattern, with one long hold-off so the block backs up.
    initial
    begin : rsp_stall_pattern
        stall_mode_t mode;
        int          span;
        int          elapsed;
        bit          long_hold_done;
        rsp_stall      = 1'b0;
        elapsed        = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 60);
            if (!long_hold_done && elapsed >= LONG_HOLD_START)
            begin
                mode           = STALL_HOLD;
                span           = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:      rsp_stall <= 1'b0;
                    STALL_COIN:      rsp_stall <= ($urandom_range(0, 1) == 1);
                    STALL_ALTERNATE: rsp_stall <= ~rsp_stall;
                    STALL_HEAVY:     rsp_stall <= ($urandom_range(0, 3) != 0);
                    default:         rsp_stall <= 1'b1;
                endcase
            end
            elapsed += span;
        end
    end

    // Response checker: each accepted transaction against the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got status %0d",
                         $time, status);
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (status !== oldest.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest.status, status);
                    error_count++;
                end
                if (removed_value !== oldest.removed)
                begin
                    $display("%0t: removed_value expected %0d, got %0d",
                             $time, oldest.removed, removed_value);
                    error_count++;
                end
                if (list_length !== oldest.length)
                begin
                    $display("%0t: list_length expected %0d, got %0d",
                             $time, oldest.length, list_length);
                    error_count++;
                end
            end
        end
    end

    // Cycles without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: ends the run if the block stops moving.
    initial
    begin
        quiet_cycles = 0;
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout after %0d cycles without a transaction", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
